@@ hw/rtl/btt_pkg.sv @@
// Shared types, codes and constants of the bracket text tokenizer.
package btt_pkg;

   localparam int VALUE_WIDTH_DEF    = 64;
   localparam int POSITION_WIDTH_DEF = 24;

   localparam int CHAR_W    = 21;
   localparam int POS_OUT_W = 24;
   localparam int NUM_W     = 64;

   localparam int MAX_RES = 3;
   localparam int CNT_W   = 2;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 21'h09;
   localparam logic [CHAR_W-1:0] CH_LF     = 21'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 21'h0D;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 21'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK = 21'h5D;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 21'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 21'h29;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 21'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 21'h7D;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'h22;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 21'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 21'h39;

   typedef enum logic [2:0] {
      EV_SINGLE = 3'd0,
      EV_VALUE  = 3'd1,
      EV_END    = 3'd2,
      EV_ERROR  = 3'd3,
      EV_EOT    = 3'd4
   } event_code_type;

   typedef enum logic [3:0] {
      TK_LBRACK = 4'd0,
      TK_RBRACK = 4'd1,
      TK_LPAREN = 4'd2,
      TK_RPAREN = 4'd3,
      TK_LBRACE = 4'd4,
      TK_RBRACE = 4'd5,
      TK_STRING = 4'd6,
      TK_WORD   = 4'd7,
      TK_NUMBER = 4'd8
   } tok_kind_type;

   typedef enum logic [1:0] {
      CA_UNTERM = 2'd0,
      CA_TOUCH  = 2'd1,
      CA_FORMAT = 2'd2,
      CA_RANGE  = 2'd3
   } cause_type;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_STRING  = 5'b00010,
      MODE_WORD    = 5'b00100,
      MODE_AFTER   = 5'b01000,
      MODE_STOPPED = 5'b10000
   } mode_type;

   typedef struct packed {
      event_code_type         ev;
      tok_kind_type           kind;
      logic [POS_OUT_W-1:0]   line;
      logic [POS_OUT_W-1:0]   col;
      logic [CHAR_W-1:0]      vchar;
      logic [NUM_W-1:0]       num;
      cause_type              cause;
   } result_type;

   // All results of one input word.
   typedef struct packed {
      logic [CNT_W-1:0]             count;
      result_type [MAX_RES-1:0]     res;
   } bundle_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

@@ hw/rtl/btt_front.sv @@
// Front end: scanner state, classification and result bundle building.
module btt_front
   import btt_pkg::*;
#(
   parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              end_of_text,
   output logic              push,
   output bundle_type        push_data
);

   localparam int VW = VALUE_WIDTH;
   localparam int PW = POSITION_WIDTH;
   localparam int WW = VALUE_WIDTH + 4;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
   localparam logic [PW-1:0] POS_ONE = PW'(1);

   typedef struct packed {
      event_code_type   ev;
      tok_kind_type     kind;
      logic [NUM_W-1:0] num;
      cause_type        cause;
      logic             err;
   } fin_type;

   mode_type          mode_ff, mode_in;
   logic [PW-1:0]     cur_line_ff, cur_line_in, cur_col_ff, cur_col_in;
   logic [PW-1:0]     tok_line_ff, tok_line_in, tok_col_ff, tok_col_in;
   logic              cr_ff, cr_in;
   logic [1:0]        wl_ff, wl_in;
   logic [CHAR_W-1:0] first_ff, first_in;
   logic              neg_ff, neg_in, fb_ff, fb_in, oor_ff, oor_in;
   logic [VW-1:0]     acc_ff, acc_in;

   logic [CNT_W-1:0]         n;
   result_type [MAX_RES-1:0] res;
   logic                     ok, ws, bt_hit, quote, bad, is_dig;
   tok_kind_type             bt_kind;
   logic [3:0]               dval;
   logic [WW-1:0]            wide, limit;
   fin_type                  fin;

   function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic result_type mk_res(input event_code_type ev, input tok_kind_type kind,
                                         input logic [PW-1:0] line, input logic [PW-1:0] col,
                                         input logic [CHAR_W-1:0] vch,
                                         input logic [NUM_W-1:0] num, input cause_type cause);
      result_type r;
      r.ev    = ev;
      r.kind  = kind;
      r.line  = POS_OUT_W'(line);
      r.col   = POS_OUT_W'(col);
      r.vchar = vch;
      r.num   = num;
      r.cause = cause;
      return r;
   endfunction

   function automatic fin_type finish(input logic [CHAR_W-1:0] first, input logic [1:0] wl,
                                      input logic fb, input logic oor, input logic neg,
                                      input logic [VW-1:0] acc);
      fin_type          f;
      logic signed [VW-1:0] v;
      v       = neg ? signed'(VW'(0) - acc) : signed'(acc);
      f.ev    = EV_END;
      f.kind  = TK_WORD;
      f.num   = '0;
      f.cause = CA_UNTERM;
      f.err   = 1'b0;
      if (is_digit(first) || (first == CH_MINUS && wl >= 2'd2)) begin
         if (fb) begin
            f.ev    = EV_ERROR;
            f.kind  = TK_NUMBER;
            f.cause = CA_FORMAT;
            f.err   = 1'b1;
         end else if (oor) begin
            f.ev    = EV_ERROR;
            f.kind  = TK_NUMBER;
            f.cause = CA_RANGE;
            f.err   = 1'b1;
         end else begin
            f.kind = TK_NUMBER;
            f.num  = NUM_W'(v);
         end
      end
      return f;
   endfunction

   always_comb begin
      bt_hit  = 1'b1;
      bt_kind = TK_LBRACK;
      case (char_code)
         CH_LBRACK: bt_kind = TK_LBRACK;
         CH_RBRACK: bt_kind = TK_RBRACK;
         CH_LPAREN: bt_kind = TK_LPAREN;
         CH_RPAREN: bt_kind = TK_RPAREN;
         CH_LBRACE: bt_kind = TK_LBRACE;
         CH_RBRACE: bt_kind = TK_RBRACE;
         default:   bt_hit  = 1'b0;
      endcase
   end

   assign ws     = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                   (char_code == CH_LF) || (char_code == CH_CR);
   assign quote  = (char_code == CH_QUOTE);
   assign is_dig = is_digit(char_code);
   assign dval   = char_code[3:0];

   // acc*10 + d against the signed limit, one shift-add and compare
   assign wide  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + WW'(dval);
   assign limit = (WW'(1) << (VW - 1)) - WW'(!neg_ff);

   always_comb begin
      mode_in     = mode_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      cr_in       = cr_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      wl_in       = wl_ff;
      first_in    = first_ff;
      neg_in      = neg_ff;
      fb_in       = fb_ff;
      oor_in      = oor_ff;
      acc_in      = acc_ff;
      n           = '0;
      res         = '0;
      ok          = 1'b1;
      bad         = 1'b0;
      fin         = finish(first_ff, wl_ff, fb_ff, oor_ff, neg_ff, acc_ff);

      if (mode_ff == MODE_STOPPED) begin
         ok = 1'b0;
      end else if (mode_ff == MODE_STRING) begin
         if (quote) begin
            res[n] = mk_res(EV_END, TK_STRING, tok_line_ff, tok_col_ff, '0, '0, CA_UNTERM);
            n = n + 1'b1;
            mode_in = MODE_AFTER;
         end else begin
            res[n] = mk_res(EV_VALUE, TK_STRING, tok_line_ff, tok_col_ff, char_code, '0,
                            CA_UNTERM);
            n = n + 1'b1;
         end
      end else begin
         if (mode_ff == MODE_WORD) begin
            if (quote) begin
               res[n] = mk_res(EV_ERROR, TK_WORD, tok_line_ff, tok_col_ff, '0, '0, CA_TOUCH);
               n = n + 1'b1;
               ok = 1'b0;
            end else if (ws || bt_hit) begin
               res[n] = mk_res(fin.ev, fin.kind, tok_line_ff, tok_col_ff, '0, fin.num,
                               fin.cause);
               n = n + 1'b1;
               if (fin.err) ok = 1'b0;
               else mode_in = MODE_IDLE;
            end else begin
               if (wl_ff != 2'd2) wl_in = wl_ff + 2'd1;
               if (first_ff == CH_MINUS) begin
                  bad = !is_dig || (wl_ff == 2'd1 && char_code == CH_ZERO);
               end else begin
                  bad = (wl_ff == 2'd1 && first_ff == CH_ZERO) || !is_dig;
               end
               if (bad) begin
                  fb_in = 1'b1;
               end else if (!fb_ff && !oor_ff) begin
                  if (wide > limit) oor_in = 1'b1;
                  else acc_in = VW'(wide);
               end
               res[n] = mk_res(EV_VALUE, TK_WORD, tok_line_ff, tok_col_ff, char_code, '0,
                               CA_UNTERM);
               n = n + 1'b1;
            end
         end else if (ws) begin
            mode_in = MODE_IDLE;
         end else if (bt_hit) begin
            mode_in = mode_ff;
         end else if (mode_ff == MODE_AFTER) begin
            res[n] = mk_res(EV_ERROR, quote ? TK_STRING : TK_WORD, cur_line_ff, cur_col_ff,
                            '0, '0, CA_TOUCH);
            n = n + 1'b1;
            ok = 1'b0;
         end else if (quote) begin
            tok_line_in = cur_line_ff;
            tok_col_in  = cur_col_ff;
            mode_in     = MODE_STRING;
         end else begin
            tok_line_in = cur_line_ff;
            tok_col_in  = cur_col_ff;
            first_in    = char_code;
            wl_in       = 2'd1;
            neg_in      = (char_code == CH_MINUS);
            fb_in       = 1'b0;
            oor_in      = 1'b0;
            acc_in      = is_dig ? VW'(dval) : '0;
            mode_in     = MODE_WORD;
            res[n] = mk_res(EV_VALUE, TK_WORD, cur_line_ff, cur_col_ff, char_code, '0,
                            CA_UNTERM);
            n = n + 1'b1;
         end
         if (ok && bt_hit) begin
            res[n] = mk_res(EV_SINGLE, bt_kind, cur_line_ff, cur_col_ff, '0, '0, CA_UNTERM);
            n = n + 1'b1;
            mode_in = MODE_IDLE;
         end
      end

      if (ok) begin
         if (char_code == CH_CR) begin
            cur_line_in = pos_inc(cur_line_ff);
            cur_col_in  = POS_ONE;
            cr_in       = 1'b1;
         end else if (char_code == CH_LF) begin
            if (!cr_ff) cur_line_in = pos_inc(cur_line_ff);
            cur_col_in = POS_ONE;
            cr_in      = 1'b0;
         end else begin
            cur_col_in = pos_inc(cur_col_ff);
            cr_in      = 1'b0;
         end
      end

      if (ok && end_of_text) begin
         if (mode_in == MODE_WORD) begin
            fin = finish(first_in, wl_in, fb_in, oor_in, neg_in, acc_in);
            res[n] = mk_res(fin.ev, fin.kind, tok_line_in, tok_col_in, '0, fin.num,
                            fin.cause);
            n = n + 1'b1;
            if (fin.err) ok = 1'b0;
         end else if (mode_in == MODE_STRING) begin
            res[n] = mk_res(EV_ERROR, TK_STRING, tok_line_in, tok_col_in, '0, '0, CA_UNTERM);
            n = n + 1'b1;
            ok = 1'b0;
         end
         if (ok) begin
            res[n] = mk_res(EV_EOT, TK_LBRACK, cur_line_ff, cur_col_ff, '0, '0, CA_UNTERM);
            n = n + 1'b1;
            mode_in     = MODE_IDLE;
            cur_line_in = POS_ONE;
            cur_col_in  = POS_ONE;
            cr_in       = 1'b0;
            tok_line_in = POS_ONE;
            tok_col_in  = POS_ONE;
            wl_in       = 2'd0;
            first_in    = '0;
            neg_in      = 1'b0;
            fb_in       = 1'b0;
            oor_in      = 1'b0;
            acc_in      = '0;
         end
      end

      if (!ok) mode_in = MODE_STOPPED;
   end

   assign push            = accept && (n != '0);
   assign push_data.count = n;
   assign push_data.res   = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         cur_line_ff <= POS_ONE;
         cur_col_ff  <= POS_ONE;
         cr_ff       <= 1'b0;
         tok_line_ff <= POS_ONE;
         tok_col_ff  <= POS_ONE;
         wl_ff       <= 2'd0;
         first_ff    <= '0;
         neg_ff      <= 1'b0;
         fb_ff       <= 1'b0;
         oor_ff      <= 1'b0;
         acc_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         cr_ff       <= cr_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         wl_ff       <= wl_in;
         first_ff    <= first_in;
         neg_ff      <= neg_in;
         fb_ff       <= fb_in;
         oor_ff      <= oor_in;
         acc_ff      <= acc_in;
      end
   end

   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_STOPPED |=> mode_ff == MODE_STOPPED)
      else $error("stopped scanner left its stop state");

   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      cur_col_ff != '0 && cur_line_ff != '0)
      else $error("position counter reached zero");

endmodule

@@ hw/rtl/btt_queue.sv @@
// Two-entry bundle queue between the scanner front and the output back end.
module btt_queue
   import btt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output logic       q_valid,
   output logic       full,
   output bundle_type q_data
);

   bundle_type         mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue read while empty");

endmodule

@@ hw/rtl/btt_back.sv @@
// Back end: takes bundles from the queue and sends their results one word a cycle while rsp_ready is high.
module btt_back
   import btt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  bundle_type           q_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_event_res,
   output logic [3:0]           rsp_token_type,
   output logic [POS_OUT_W-1:0] rsp_start_line,
   output logic [POS_OUT_W-1:0] rsp_start_column,
   output logic [CHAR_W-1:0]    rsp_value_char,
   output logic [NUM_W-1:0]     rsp_number_value,
   output logic [1:0]           rsp_error_cause,
   output logic                 rsp_final_of_run
);

   logic             valid_ff, valid_in;
   bundle_type       bundle_ff, bundle_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   result_type       cur;
   logic             last, take;

   assign cur  = bundle_ff.res[idx_ff];
   assign last = (idx_ff == bundle_ff.count - 1'b1);
   assign take = valid_ff && rsp_ready;
   assign pop  = q_valid && (!valid_ff || (take && last));

   always_comb begin
      valid_in  = valid_ff;
      bundle_in = bundle_ff;
      idx_in    = idx_ff;
      if (pop) begin
         valid_in  = 1'b1;
         bundle_in = q_data;
         idx_in    = '0;
      end else if (take && last) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_res    = cur.ev;
   assign rsp_token_type   = cur.kind;
   assign rsp_start_line   = cur.line;
   assign rsp_start_column = cur.col;
   assign rsp_value_char   = cur.vchar;
   assign rsp_number_value = cur.num;
   assign rsp_error_cause  = cur.cause;
   assign rsp_final_of_run = last;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bundle_ff.count != '0) && (idx_ff < bundle_ff.count))
      else $error("result index outside its bundle");

endmodule

@@ hw/rtl/bracket_text_tokenizer_core.sv @@
// Top level of the bracket text tokenizer: front scanner, bundle queue, output back end.
//
//  channel | ports                                        | direction
//  req     | req_valid req_ready req_char_code req_end_of_text | in, one character a word
//  rsp     | rsp_valid rsp_ready rsp_event_res ... rsp_final_of_run | out, one result a word
//
// The front scans one character per cycle while the queue is not full and turns it into
// a bundle of zero to three results; the back sends one result per cycle while rsp_ready
// is high, so the sustained rate is one character per cycle while characters yield at
// most one result each. Each bundle is registered in the queue and then in the back end.
// A stalled rsp side backs up a two-bundle queue before req_ready drops.
// Reset is synchronous and returns the scanner to the start of a text.
module bracket_text_tokenizer_core
   import btt_pkg::*;
#(
   parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic                 req_end_of_text,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_event_res,
   output logic [3:0]           rsp_token_type,
   output logic [POS_OUT_W-1:0] rsp_start_line,
   output logic [POS_OUT_W-1:0] rsp_start_column,
   output logic [CHAR_W-1:0]    rsp_value_char,
   output logic [NUM_W-1:0]     rsp_number_value,
   output logic [1:0]           rsp_error_cause,
   output logic                 rsp_final_of_run
);

   logic       accept, push, pop, q_valid, full;
   bundle_type push_data, q_data;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   btt_front #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .push        (push),
      .push_data   (push_data)
   );

   btt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .full      (full),
      .q_data    (q_data)
   );

   btt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_token_type   (rsp_token_type),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_value_char   (rsp_value_char),
      .rsp_number_value (rsp_number_value),
      .rsp_error_cause  (rsp_error_cause),
      .rsp_final_of_run (rsp_final_of_run)
   );

endmodule

@@ verif/tb_bracket_text_tokenizer_core.sv @@
// Self-checking testbench for bracket_text_tokenizer_core: random texts, stalls, scanner model.
module tb_bracket_text_tokenizer_core;
   import btt_pkg::*;

   localparam int P_W = POSITION_WIDTH_DEF;
   localparam tok_kind_type NO_KIND  = TK_LBRACK;   // token_type field when unused
   localparam cause_type    NO_CAUSE = CA_UNTERM;   // error_cause field outside errors
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eot;
   } char_word_type;

   typedef struct packed {
      event_code_type       ev;
      tok_kind_type         kind;
      logic [POS_OUT_W-1:0] line;
      logic [POS_OUT_W-1:0] col;
      logic [CHAR_W-1:0]    vch;
      logic [NUM_W-1:0]     num;
      cause_type            cause;
      logic                 fin;
   } tok_event_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic                 req_end_of_text = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_event_res;
   logic [3:0]           rsp_token_type;
   logic [POS_OUT_W-1:0] rsp_start_line;
   logic [POS_OUT_W-1:0] rsp_start_column;
   logic [CHAR_W-1:0]    rsp_value_char;
   logic [NUM_W-1:0]     rsp_number_value;
   logic [1:0]           rsp_error_cause;
   logic                 rsp_final_of_run;

   bracket_text_tokenizer_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_char_code(req_char_code), .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res), .rsp_token_type(rsp_token_type),
      .rsp_start_line(rsp_start_line), .rsp_start_column(rsp_start_column),
      .rsp_value_char(rsp_value_char), .rsp_number_value(rsp_number_value),
      .rsp_error_cause(rsp_error_cause), .rsp_final_of_run(rsp_final_of_run)
   );

   always #6 clock = ~clock;

   char_word_type send_queue[$];
   tok_event_type expected_events[$];
   char_word_type next_word;
   tok_event_type want;
   bit         failed = 1'b0;
   int         accepted = 0;
   int         step_count;
   int         send_gap = 0;
   int         stall_left = 0;
   int         rx_ticks = 0;
   int         cycle_count = 0;
   logic       calm = 1'b0;

   // scanner state
   mode_type           mode;
   logic [P_W-1:0]     line_now, col_now, tok_line, tok_col;
   logic               cr_seen, neg, bad_fmt, too_big;
   int                 wlen;
   logic [CHAR_W-1:0]  first_ch;
   logic [NUM_W-1:0]   acc;

   function automatic logic numeral(input logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic is_bracket(input logic [CHAR_W-1:0] c);
      return c == CH_LBRACK || c == CH_RBRACK || c == CH_LPAREN ||
             c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE;
   endfunction

   function automatic tok_kind_type bracket_kind(input logic [CHAR_W-1:0] c);
      case (c)
         CH_LBRACK: return TK_LBRACK;
         CH_RBRACK: return TK_RBRACK;
         CH_LPAREN: return TK_LPAREN;
         CH_RPAREN: return TK_RPAREN;
         CH_LBRACE: return TK_LBRACE;
         default:   return TK_RBRACE;
      endcase
   endfunction

   function automatic logic [P_W-1:0] bump(input logic [P_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void reset_scanner();
      mode = MODE_IDLE;
      line_now = 1; col_now = 1; cr_seen = 1'b0;
      tok_line = 1; tok_col = 1;
      wlen = 0; first_ch = '0;
      neg = 1'b0; bad_fmt = 1'b0; too_big = 1'b0;
      acc = '0;
   endfunction

   function automatic void add_event(input event_code_type e, input tok_kind_type k,
                                     input logic [P_W-1:0] l, input logic [P_W-1:0] c,
                                     input logic [CHAR_W-1:0] v, input logic [NUM_W-1:0] n,
                                     input cause_type ca);
      tok_event_type x;
      x.ev = e; x.kind = k;
      x.line = POS_OUT_W'(l); x.col = POS_OUT_W'(c);
      x.vch = v; x.num = n; x.cause = ca; x.fin = 1'b0;
      expected_events.push_back(x);
      step_count++;
   endfunction

   function automatic void add_digit(input logic [CHAR_W-1:0] c);
      logic [NUM_W-1:0] d, limit;
      if (bad_fmt || too_big) return;
      d = NUM_W'(c - CH_ZERO);
      limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (acc > (limit - d) / 10) too_big = 1'b1;
      else acc = acc * 10 + d;
   endfunction

   function automatic void append_word_char(input logic [CHAR_W-1:0] c);
      int prev;
      prev = wlen;
      if (wlen < 2) wlen++;
      if (first_ch == CH_MINUS) begin
         if (!numeral(c) || (prev == 1 && c == CH_ZERO)) bad_fmt = 1'b1;
         else add_digit(c);
      end else begin
         if ((prev == 1 && first_ch == CH_ZERO) || !numeral(c)) bad_fmt = 1'b1;
         else add_digit(c);
      end
   endfunction

   function automatic logic close_word();
      logic numeric;
      numeric = numeral(first_ch) || (first_ch == CH_MINUS && wlen >= 2);
      if (!numeric) begin
         add_event(EV_END, TK_WORD, tok_line, tok_col, '0, '0, NO_CAUSE);
      end else if (bad_fmt) begin
         add_event(EV_ERROR, TK_NUMBER, tok_line, tok_col, '0, '0, CA_FORMAT);
         return 1'b0;
      end else if (too_big) begin
         add_event(EV_ERROR, TK_NUMBER, tok_line, tok_col, '0, '0, CA_RANGE);
         return 1'b0;
      end else begin
         add_event(EV_END, TK_NUMBER, tok_line, tok_col, '0, neg ? -acc : acc, NO_CAUSE);
      end
      mode = MODE_IDLE;
      return 1'b1;
   endfunction

   function automatic void tokenize_char(input logic [CHAR_W-1:0] c, input logic eot);
      logic [P_W-1:0] pl, pc;
      logic ws, br, ok;
      tok_event_type last;
      pl = line_now; pc = col_now;
      ws = is_space(c); br = is_bracket(c); ok = 1'b1;
      step_count = 0;
      if (mode == MODE_STOPPED) return;
      if (mode == MODE_STRING) begin
         if (c == CH_QUOTE) begin
            add_event(EV_END, TK_STRING, tok_line, tok_col, '0, '0, NO_CAUSE);
            mode = MODE_AFTER;
         end else begin
            add_event(EV_VALUE, TK_STRING, tok_line, tok_col, c, '0, NO_CAUSE);
         end
      end else begin
         if (mode == MODE_WORD) begin
            if (c == CH_QUOTE) begin
               add_event(EV_ERROR, TK_WORD, tok_line, tok_col, '0, '0, CA_TOUCH);
               ok = 1'b0;
            end else if (ws || br) begin
               ok = close_word();
            end else begin
               append_word_char(c);
               add_event(EV_VALUE, TK_WORD, tok_line, tok_col, c, '0, NO_CAUSE);
            end
         end else if (ws) begin
            mode = MODE_IDLE;
         end else if (br) begin
            mode = mode;
         end else if (mode == MODE_AFTER) begin
            add_event(EV_ERROR, (c == CH_QUOTE) ? TK_STRING : TK_WORD, pl, pc, '0, '0,
                      CA_TOUCH);
            ok = 1'b0;
         end else if (c == CH_QUOTE) begin
            tok_line = pl; tok_col = pc;
            mode = MODE_STRING;
         end else begin
            tok_line = pl; tok_col = pc;
            first_ch = c; wlen = 1;
            neg = (c == CH_MINUS);
            bad_fmt = 1'b0; too_big = 1'b0;
            acc = numeral(c) ? NUM_W'(c - CH_ZERO) : '0;
            mode = MODE_WORD;
            add_event(EV_VALUE, TK_WORD, tok_line, tok_col, c, '0, NO_CAUSE);
         end
         if (ok && br) begin
            add_event(EV_SINGLE, bracket_kind(c), pl, pc, '0, '0, NO_CAUSE);
            mode = MODE_IDLE;
         end
      end
      if (ok) begin
         if (c == CH_CR) begin
            line_now = bump(line_now); col_now = 1; cr_seen = 1'b1;
         end else if (c == CH_LF) begin
            if (!cr_seen) line_now = bump(line_now);
            col_now = 1; cr_seen = 1'b0;
         end else begin
            col_now = bump(col_now); cr_seen = 1'b0;
         end
      end
      if (ok && eot) begin
         if (mode == MODE_WORD) begin
            ok = close_word();
         end else if (mode == MODE_STRING) begin
            add_event(EV_ERROR, TK_STRING, tok_line, tok_col, '0, '0, CA_UNTERM);
            ok = 1'b0;
         end
         if (ok) begin
            add_event(EV_EOT, NO_KIND, pl, pc, '0, '0, NO_CAUSE);
            reset_scanner();
         end
      end
      if (!ok) mode = MODE_STOPPED;
      if (step_count > 0) begin
         last = expected_events.pop_back();
         last.fin = 1'b1;
         expected_events.push_back(last);
      end
   endfunction

   function automatic void check_field(input string what, input logic [NUM_W-1:0] exp_v,
                                       input logic [NUM_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
         failed = 1'b1;
      end
   endfunction

   // ---------------- stimulus generation ----------------
   function automatic int pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic void push_ch(input logic [CHAR_W-1:0] c);
      char_word_type w;
      w.ch = c; w.eot = 1'b0;
      send_queue.push_back(w);
   endfunction

   function automatic void end_text();
      char_word_type w;
      w = send_queue.pop_back();
      w.eot = 1'b1;
      send_queue.push_back(w);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_code();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return CHAR_W'($urandom_range('h21, 'h7E));
      if (r < 8) return CHAR_W'($urandom_range(0, 'hFFFF));
      return CHAR_W'($urandom_range(0, 'h10FFFF));
   endfunction

   function automatic logic [CHAR_W-1:0] word_start();
      logic [CHAR_W-1:0] c;
      do c = rand_code();
      while (is_space(c) || is_bracket(c) || c == CH_QUOTE || numeral(c) || c == CH_MINUS);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] word_tail();
      logic [CHAR_W-1:0] c;
      do c = rand_code();
      while (is_space(c) || is_bracket(c) || c == CH_QUOTE);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] any_bracket();
      case ($urandom_range(0, 5))
         0: return CH_LBRACK;
         1: return CH_RBRACK;
         2: return CH_LPAREN;
         3: return CH_RPAREN;
         4: return CH_LBRACE;
         default: return CH_RBRACE;
      endcase
   endfunction

   function automatic void push_sep();
      case ($urandom_range(0, 9))
         0, 1, 2: push_ch(CH_SPACE);
         3: push_ch(CH_TAB);
         4: push_ch(CH_LF);
         5: push_ch(CH_CR);
         6: begin push_ch(CH_CR); push_ch(CH_LF); end
         7: begin push_ch(CH_CR); push_ch(CH_CR); end
         8: begin push_ch(CH_LF); push_ch(CH_CR); end
         default: push_ch(any_bracket());
      endcase
   endfunction

   function automatic void push_word();
      push_ch(word_start());
      repeat ($urandom_range(0, 4)) push_ch(word_tail());
   endfunction

   function automatic void push_string();
      logic [CHAR_W-1:0] c;
      push_ch(CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(0, 6) == 0) c = $urandom_range(0, 1) ? CH_CR : CH_LF;
         else do c = rand_code(); while (c == CH_QUOTE);
         push_ch(c);
      end
      push_ch(CH_QUOTE);
   endfunction

   function automatic void push_decimal(input logic minus, input logic [NUM_W-1:0] mag);
      logic [NUM_W-1:0] m;
      byte unsigned digs[$];
      m = mag;
      do begin
         digs.push_front(8'(m % 10));
         m = m / 10;
      end while (m != 0);
      if (minus) push_ch(CH_MINUS);
      foreach (digs[i]) push_ch(CH_ZERO + CHAR_W'(digs[i]));
   endfunction

   function automatic void push_number();
      logic [NUM_W-1:0] mag;
      logic minus;
      minus = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0: mag = '0;
         1: mag = $urandom_range(0, 9);
         2, 3, 4: mag = $urandom_range(0, 99999);
         5, 6: mag = {1'b0, 31'($urandom), $urandom};
         7: begin mag = 64'h7FFF_FFFF_FFFF_FFFF; minus = 1'b0; end
         8: begin mag = 64'h8000_0000_0000_0000; minus = 1'b1; end
         default: mag = $urandom;
      endcase
      if (mag == 0) minus = 1'b0;
      push_decimal(minus, mag);
   endfunction

   function automatic void gen_text();
      int n;
      bit needs_sep;
      if ($urandom_range(0, 19) == 0) begin
         push_sep();
         end_text();
         return;
      end
      if ($urandom_range(0, 4) == 0) push_sep();
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         needs_sep = 1'b1;
         case ($urandom_range(0, 9))
            0, 1: begin push_ch(any_bracket()); needs_sep = 1'b0; end
            2, 3: push_word();
            4: push_ch(CH_MINUS);
            5, 6, 7: push_number();
            default: push_string();
         endcase
         if (i == n - 1 && $urandom_range(0, 1)) break;
         if (needs_sep || $urandom_range(0, 1)) push_sep();
      end
      end_text();
   endfunction

   // one terminal error, then words the stopped block must swallow silently
   function automatic void push_fault();
      case ($urandom_range(0, 8))
         0: begin push_ch(CH_QUOTE); push_ch(word_start()); end
         1: begin push_ch(CH_QUOTE); push_ch(word_start()); push_ch(CH_QUOTE);
                  push_ch(CH_QUOTE); end
         2: begin push_ch(CH_QUOTE); push_ch(CH_QUOTE); push_ch(word_start()); end
         3: begin push_ch(word_start()); push_ch(CH_QUOTE); end
         4: begin push_ch(CH_MINUS); push_ch(CH_ZERO); push_ch(CH_SPACE); end
         5: begin push_ch(CH_ZERO); push_ch(CH_ZERO + 21'd7); push_ch(CH_SPACE); end
         6: begin push_decimal(1'b0, 64'h8000_0000_0000_0000); push_ch(CH_SPACE); end
         7: begin push_decimal(1'b1, 64'h8000_0000_0000_0001); push_ch(CH_SPACE); end
         default: begin
            repeat (20) push_ch(CH_NINE);
            push_ch(word_start());
            push_ch(CH_SPACE);
         end
      endcase
      end_text();
      repeat (4) push_ch(rand_code());
      end_text();
   endfunction

   // ---------------- processes ----------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm <= ((cycle_count / 100) % 3) == 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (send_queue.size() > 0) begin
            next_word = send_queue.pop_front();
            req_valid <= 1'b1;
            req_char_code <= next_word.ch;
            req_end_of_text <= next_word.eot;
            send_gap = calm ? 0 : pick_pause();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      int p;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         rx_ticks = 0;
      end else begin
         rx_ticks++;
         if (rx_ticks == 120) stall_left = 120;   // long hold-off to back up the input
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            p = pick_pause();
            if (p > 0) begin
               rsp_ready <= 1'b0;
               stall_left = p - 1;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         reset_scanner();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected result, expected none, got event %0d type %0d",
                        $time, rsp_event_res, rsp_token_type);
               failed = 1'b1;
            end else begin
               want = expected_events.pop_front();
               check_field("event_res", 64'(want.ev), 64'(rsp_event_res));
               check_field("token_type", 64'(want.kind), 64'(rsp_token_type));
               check_field("start_line", 64'(want.line), 64'(rsp_start_line));
               check_field("start_column", 64'(want.col), 64'(rsp_start_column));
               check_field("value_char", 64'(want.vch), 64'(rsp_value_char));
               check_field("number_value", want.num, rsp_number_value);
               check_field("error_cause", 64'(want.cause), 64'(rsp_error_cause));
               check_field("final_of_run", 64'(want.fin), 64'(rsp_final_of_run));
            end
         end
         if (req_valid && req_ready) begin
            accepted++;
            tokenize_char(req_char_code, req_end_of_text);
         end
      end
   end

   initial begin
      logic [CHAR_W-1:0] opening_text [21];
      int total;
      opening_text = '{
         CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
         CH_CR, CH_LF, CH_QUOTE, CH_LF, CH_QUOTE, CH_CR,
         21'h10FFFF, 21'h0, CH_TAB, CH_MINUS, CH_LF,
         CH_MINUS, CH_ZERO + 21'd7, CH_SPACE, CH_ZERO};
      foreach (opening_text[i]) push_ch(opening_text[i]);
      end_text();
      while (send_queue.size() < 230) gen_text();
      push_fault();
      total = send_queue.size();
      do @(posedge clock); while (accepted < total);
      do @(posedge clock); while (expected_events.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failed)
         $display("CHECK FAILED");
      else
         $display("CHECK OK");
      $finish;
   end

   initial begin
      #2400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ bracket_text_tokenizer_core.f @@
hw/rtl/btt_pkg.sv
hw/rtl/btt_front.sv
hw/rtl/btt_queue.sv
hw/rtl/btt_back.sv
hw/rtl/bracket_text_tokenizer_core.sv
verif/tb_bracket_text_tokenizer_core.sv
